### sv/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg : shared types and constants for the buoyancy vorticity stencil
// Fixed-point defaults, operation codes of the shared unit, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package bvs_pkg;
  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF   = 40;
  localparam int unsigned FRAC_BITS_DEF   = 24;
  localparam int unsigned FIELD_W         = 40;
  localparam int unsigned UFIELD_W        = 39;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 39;
  localparam int unsigned IN_TDATA_W      = 280;
  localparam int unsigned OUT_TDATA_W     = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY    = 3'd0,
    REG_INV_DX     = 3'd1,
    REG_TWO_DT     = 3'd2,
    REG_WATER_MODE = 3'd3,
    REG_ROW_LENGTH = 3'd4,
    REG_ROW_COUNT  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_MUL = 4'b0001,
    OP_DIV = 4'b0010,
    OP_ADD = 4'b0100,
    OP_SUB = 4'b1000
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_ISSUE = 6'b000100,
    ST_BUSY  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;
endpackage
`default_nettype wire

### sv/bvs_alu.sv
// ----------------------------------------------------------------------------
// bvs_alu : shared iterative arithmetic unit
// Fixed-point multiply (one operand bit a cycle), division (one quotient bit
// a cycle) and saturating add and subtract. Results saturate to the word range.
// ----------------------------------------------------------------------------
`default_nettype none
module bvs_alu #(
  parameter int unsigned WORD_BITS = bvs_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = bvs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire bvs_pkg::op_t                op,
  input  wire logic signed [WORD_BITS-1:0] a,
  input  wire logic signed [WORD_BITS-1:0] b,
  output logic                             done,
  output logic signed [WORD_BITS-1:0]      y
);
  import bvs_pkg::*;

  localparam int unsigned MW   = WORD_BITS;            // magnitude width
  localparam int unsigned PW   = 2 * WORD_BITS;        // product width
  localparam int unsigned NW   = WORD_BITS + FRAC_BITS; // dividend width
  localparam int unsigned CW   = $clog2(NW + 1);
  localparam logic [MW-1:0] LIM_P = {1'b0, {(MW-1){1'b1}}};
  localparam logic [MW-1:0] LIM_N = {1'b1, {(MW-1){1'b0}}};

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  op_t             op_r, op_nxt;
  logic            neg_r, neg_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [MW-1:0]   mb_r, mb_nxt;          // multiplier / divisor
  logic [NW-1:0]   sh_r, sh_nxt;          // multiplicand (low MW) or dividend
  logic [PW-1:0]   acc_r, acc_nxt;        // product
  logic [MW:0]     rem_r, rem_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic signed [WORD_BITS-1:0] y_r, y_nxt;

  logic [MW-1:0] ma, mbv;
  logic [MW:0]   rtry;
  logic [MW:0]   rdiff;
  logic signed [WORD_BITS:0] ax, bx;
  logic signed [WORD_BITS:0] sum;
  logic [PW-1:0] pshift;
  logic          ovf;
  logic [MW-1:0] mag;

  function automatic logic [MW-1:0] absv(input logic signed [WORD_BITS-1:0] v);
    absv = v[WORD_BITS-1] ? MW'(-v) : MW'(v);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_mag(input logic neg,
      input logic over, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [MW-1:0] v;
    lim = neg ? LIM_N : LIM_P;
    v = (over || m > lim) ? lim : m;
    sat_mag = neg ? -$signed(v) : $signed(v);
  endfunction

  always_comb begin
    ma = absv(a);
    mbv = absv(b);
    ax = {a[WORD_BITS-1], a};
    bx = {b[WORD_BITS-1], b};
    sum = (op == OP_SUB) ? ax - bx : ax + bx;
    rtry = {rem_r[MW-1:0], sh_r[NW-1]};
    rdiff = rtry - {1'b0, mb_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt = op_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    mb_nxt = mb_r;
    sh_nxt = sh_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    y_nxt = y_r;
    ovf = 1'b0;
    mag = '0;
    if (start) begin
      op_nxt = op;
      case (op)
        OP_ADD, OP_SUB: begin
          if (sum[WORD_BITS] != sum[WORD_BITS-1])
            y_nxt = sum[WORD_BITS] ? $signed(LIM_N) : $signed(LIM_P);
          else
            y_nxt = sum[WORD_BITS-1:0];
          done_nxt = 1'b1;
        end
        OP_MUL: begin
          busy_nxt = 1'b1;
          neg_nxt = a[WORD_BITS-1] ^ b[WORD_BITS-1];
          mb_nxt = mbv;
          sh_nxt = NW'(ma);
          acc_nxt = '0;
          cnt_nxt = CW'(MW);
        end
        OP_DIV: begin
          if (b[WORD_BITS-1] || b == '0) begin
            y_nxt = (a == '0) ? '0 : (a[WORD_BITS-1] ? $signed(LIM_N) : $signed(LIM_P));
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            neg_nxt = a[WORD_BITS-1];
            mb_nxt = mbv;
            sh_nxt = {ma, {FRAC_BITS{1'b0}}};
            rem_nxt = '0;
            q_nxt = '0;
            cnt_nxt = CW'(NW);
          end
        end
        default: done_nxt = 1'b1;
      endcase
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        // shift-add, multiplier bit LSB first
        if (mb_r[0]) acc_nxt = acc_r + (PW'(sh_r[MW-1:0]) << (MW - 32'(cnt_r)));
        mb_nxt = mb_r >> 1;
      end else begin
        // restoring division, one quotient bit per cycle
        sh_nxt = sh_r << 1;
        if (!rdiff[MW]) begin
          rem_nxt = rdiff;
          q_nxt = {q_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = rtry;
          q_nxt = {q_r[NW-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    // the last step's partial product is already in acc_nxt
    pshift = acc_nxt >> FRAC_BITS;
    if (busy_r && cnt_r == CW'(1)) begin
      if (op_r == OP_MUL) begin
        ovf = |(pshift[PW-1:MW]);
        mag = pshift[MW-1:0];
      end else begin
        ovf = |(q_nxt[NW-1:MW]);
        mag = q_nxt[MW-1:0];
      end
      y_nxt = sat_mag(neg_r, ovf, mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
      op_r <= OP_ADD;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
      op_r <= op_nxt;
    end
    neg_r <= neg_nxt;
    mb_r <= mb_nxt;
    sh_r <= sh_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    y_r <= y_nxt;
  end

  assign done = done_r;
  assign y = y_r;
endmodule
`default_nettype wire

### sv/buoyancy_vorticity_stencil.sv
// ----------------------------------------------------------------------------
// buoyancy_vorticity_stencil : leapfrog buoyancy source on a vorticity grid
// One grid point per transaction; interior points get the buoyancy update.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake           | Contents
// in_     | in  | tvalid/tready       | theta, vapor, cloud, rain, zeta, dens, base_thv
// out_    | out | tvalid/tready       | zeta_out (tdata), updated (tuser)
// cfg_    | in  | write enable        | six registers, index 0..5
//
// Sequence: accept, line read, arithmetic, write-back and output. A dry boundary
// point runs no arithmetic, and a wet one runs one multiply and one add.
// Reset: synchronous, active low; clears positions, neighbour registers and
// handshakes. Line buffers are not cleared. A stalled output holds the block.
// ----------------------------------------------------------------------------
`default_nettype none
module buoyancy_vorticity_stencil #(
  parameter int unsigned MAX_COLUMNS = bvs_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned WORD_BITS   = bvs_pkg::WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS   = bvs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // theta[39:0] vapor[79:40] cloud[119:80] rain[159:120] zeta[199:160]
  // density_w[238:200] base_thv[277:239] -> padded to 280 bits
  input  wire logic [bvs_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [bvs_pkg::OUT_TDATA_W-1:0]         out_tdata,  // zeta_out[39:0]
  output logic                                    out_tuser,  // updated
  input  wire logic                               cfg_we,
  input  wire logic [bvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bvs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bvs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_COLUMNS);
  localparam int unsigned W  = WORD_BITS;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam longint unsigned K061_V = ((64'd61 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic signed [W-1:0] K061 = W'(K061_V);
  localparam logic signed [W-1:0] HALF = W'(64'd1 << (FRAC_BITS - 1));

  // clamp a 40-bit signed or 39-bit unsigned field to the word
  function automatic logic signed [W-1:0] clamps(input logic signed [FIELD_W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'(WMAX)) clamps = WMAX;
    else if (e < 64'(WMIN)) clamps = WMIN;
    else clamps = W'(e);
  endfunction
  function automatic logic signed [W-1:0] clampu(input logic [UFIELD_W-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    clampu = (e > 64'(WMAX)) ? WMAX : W'(e);
  endfunction

  // configuration
  logic [UFIELD_W-1:0] gravity_r, inv_dx_r, two_dt_r;
  logic                water_r;
  logic [10:0]         rlen_r;
  logic [15:0]         rcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= 39'd164584489;
      inv_dx_r <= 39'd83886;
      two_dt_r <= '0;
      water_r <= 1'b1;
      rlen_r <= 11'd1024;
      rcnt_r <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRAVITY:    gravity_r <= cfg_wdata;
        REG_INV_DX:     inv_dx_r <= cfg_wdata;
        REG_TWO_DT:     two_dt_r <= cfg_wdata;
        REG_WATER_MODE: water_r <= cfg_wdata[0];
        REG_ROW_LENGTH: rlen_r <= cfg_wdata[10:0];
        REG_ROW_COUNT:  rcnt_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // line buffers: one memory, three words wide
  logic [3*W-1:0] line_mem [MAX_COLUMNS];
  logic [3*W-1:0] line_q_r;

  // state
  state_t state_r, state_nxt;
  logic [4:0] pc_r, pc_nxt;          // micro-program step
  logic signed [W-1:0] th_r, qv_r, qc_r, qr_r, z_r, dens_r, bthv_r;
  logic signed [W-1:0] thv_r, gr_r, t0_r, t1_r, t2_r;
  logic signed [W-1:0] left_thv_r, left_c_r, left_r_r;
  logic signed [W-1:0] diag_thv_r, diag_c_r, diag_r_r, below_r;
  logic [15:0] col_r, row_r;
  logic interior_r;
  logic [AW-1:0] idx;
  logic [15:0] len_eff, rows_eff;

  // shared unit
  logic alu_start;
  op_t  alu_op;
  logic signed [W-1:0] alu_a, alu_b, alu_y;
  logic alu_done;

  bvs_alu #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_start), .op(alu_op),
    .a(alu_a), .b(alu_b), .done(alu_done), .y(alu_y)
  );

  logic signed [W-1:0] ln_thv, ln_c, ln_r;
  assign ln_thv = line_q_r[W-1:0];
  assign ln_c   = line_q_r[2*W-1:W];
  assign ln_r   = line_q_r[3*W-1:2*W];

  always_comb begin
    len_eff = (rlen_r < 11'd3) ? 16'd3 :
              ((32'(rlen_r) > MAX_COLUMNS) ? 16'(MAX_COLUMNS) : 16'(rlen_r));
    rows_eff = (rcnt_r < 16'd4) ? 16'd4 : rcnt_r;
    idx = (32'(col_r) < MAX_COLUMNS) ? AW'(col_r) : AW'(MAX_COLUMNS - 1);
  end

  // micro-program: step -> (op, a, b, destination); destination t0..t2, thv, gr or z
  // 0 t0=0.61*qv  1 thv=th+t0  2 gr=g/dens  3 t0=thv-left  4 t0/=bthv
  // 5 t1=ln-diag  6 t1/=below 7 t2=t0+t1   8 t1=gr*half  9 t1*=t2
  // 10 t1*=inv_dx  11 t1*=tdt   12 z+=t1 (if !water end)
  // 13 t0=qc+ln  14 t0*=half  15 t1=lc+dc 16 t1*=half 17 t0=t0-t1
  // 18 t0*=gr    19 t0*=inv_dx  20 t2=-t0 (0-pc)
  // 21..27 same for rain, 28 t2=t2-t0  29 t2*=tdt 30 z+=t2
  logic [1:0] dst;
  always_comb begin
    alu_op = OP_ADD; alu_a = '0; alu_b = '0; dst = 2'd0;
    case (pc_r)
      5'd0:  begin alu_op = OP_MUL; alu_a = K061; alu_b = qv_r; end
      5'd1:  begin alu_a = th_r; alu_b = t0_r; end
      5'd2:  begin alu_op = OP_DIV; alu_a = clampu(gravity_r); alu_b = dens_r; end
      5'd3:  begin alu_op = OP_SUB; alu_a = thv_r; alu_b = left_thv_r; end
      5'd4:  begin alu_op = OP_DIV; alu_a = t0_r; alu_b = bthv_r; end
      5'd5:  begin alu_op = OP_SUB; alu_a = ln_thv; alu_b = diag_thv_r; dst = 2'd1; end
      5'd6:  begin alu_op = OP_DIV; alu_a = t1_r; alu_b = below_r; dst = 2'd1; end
      5'd7:  begin alu_a = t0_r; alu_b = t1_r; dst = 2'd2; end
      5'd8:  begin alu_op = OP_MUL; alu_a = gr_r; alu_b = HALF; dst = 2'd1; end
      5'd9:  begin alu_op = OP_MUL; alu_a = t1_r; alu_b = t2_r; dst = 2'd1; end
      5'd10: begin alu_op = OP_MUL; alu_a = t1_r; alu_b = clampu(inv_dx_r); dst = 2'd1; end
      5'd11: begin alu_op = OP_MUL; alu_a = t1_r; alu_b = clampu(two_dt_r); dst = 2'd1; end
      5'd12: begin alu_a = z_r; alu_b = t1_r; dst = 2'd3; end
      5'd13: begin alu_a = qc_r; alu_b = ln_c; end
      5'd14: begin alu_op = OP_MUL; alu_a = HALF; alu_b = t0_r; end
      5'd15: begin alu_a = left_c_r; alu_b = diag_c_r; dst = 2'd1; end
      5'd16: begin alu_op = OP_MUL; alu_a = HALF; alu_b = t1_r; dst = 2'd1; end
      5'd17: begin alu_op = OP_SUB; alu_a = t0_r; alu_b = t1_r; end
      5'd18: begin alu_op = OP_MUL; alu_a = gr_r; alu_b = t0_r; end
      5'd19: begin alu_op = OP_MUL; alu_a = t0_r; alu_b = clampu(inv_dx_r); end
      5'd20: begin alu_op = OP_SUB; alu_a = '0; alu_b = t0_r; dst = 2'd2; end
      5'd21: begin alu_a = qr_r; alu_b = ln_r; end
      5'd22: begin alu_op = OP_MUL; alu_a = HALF; alu_b = t0_r; end
      5'd23: begin alu_a = left_r_r; alu_b = diag_r_r; dst = 2'd1; end
      5'd24: begin alu_op = OP_MUL; alu_a = HALF; alu_b = t1_r; dst = 2'd1; end
      5'd25: begin alu_op = OP_SUB; alu_a = t0_r; alu_b = t1_r; end
      5'd26: begin alu_op = OP_MUL; alu_a = gr_r; alu_b = t0_r; end
      5'd27: begin alu_op = OP_MUL; alu_a = t0_r; alu_b = clampu(inv_dx_r); end
      5'd28: begin alu_op = OP_SUB; alu_a = t2_r; alu_b = t0_r; dst = 2'd2; end
      5'd29: begin alu_op = OP_MUL; alu_a = t2_r; alu_b = clampu(two_dt_r); dst = 2'd2; end
      5'd30: begin alu_a = z_r; alu_b = t2_r; dst = 2'd3; end
      default: ;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign alu_start = (state_r == ST_ISSUE);

  // which steps run: thv steps only with water; rest only when interior, and steps 13 on only with water
  function automatic logic [4:0] next_pc(input logic [4:0] p, input logic wm,
                                         input logic intr);
    logic [4:0] n;
    n = p + 5'd1;
    if (n == 5'd2 && !intr) n = 5'd31;
    if (n == 5'd13 && !wm) n = 5'd31;
    next_pc = n;
  endfunction

  logic signed [W-1:0] res;
  assign res = alu_y;

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_READ;
      ST_READ: begin
        pc_nxt = water_r ? 5'd0 : (interior_r ? 5'd2 : 5'd31);
        state_nxt = (water_r || interior_r) ? ST_ISSUE : ST_WRITE;
      end
      ST_ISSUE: state_nxt = ST_BUSY;
      ST_BUSY: if (alu_done) begin
        pc_nxt = next_pc(pc_r, water_r, interior_r);
        state_nxt = (pc_nxt == 5'd31) ? ST_WRITE : ST_ISSUE;
      end
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic last_col;
  assign last_col = (col_r + 16'd1 >= len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= '0;
      col_r <= '0;
      row_r <= '0;
      left_thv_r <= '0; left_c_r <= '0; left_r_r <= '0;
      diag_thv_r <= '0; diag_c_r <= '0; diag_r_r <= '0;
      below_r <= '0;
      interior_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      if (state_r == ST_IDLE && in_tvalid) begin
        interior_r <= (row_r >= 16'd2) && (row_r <= rows_eff - 16'd2) &&
                      (col_r >= 16'd1) && (col_r <= len_eff - 16'd2);
      end
      if (state_r == ST_WRITE) begin
        diag_thv_r <= ln_thv; diag_c_r <= ln_c; diag_r_r <= ln_r;
        left_thv_r <= thv_r; left_c_r <= qc_r; left_r_r <= qr_r;
        if (last_col) begin
          col_r <= '0;
          below_r <= bthv_r;
          row_r <= (row_r + 16'd1 >= rows_eff) ? 16'd0 : row_r + 16'd1;
        end else begin
          col_r <= col_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      th_r <= clamps(in_tdata[39:0]);
      qv_r <= clamps(in_tdata[79:40]);
      qc_r <= clamps(in_tdata[119:80]);
      qr_r <= clamps(in_tdata[159:120]);
      z_r <= clamps(in_tdata[199:160]);
      dens_r <= clampu(in_tdata[238:200]);
      bthv_r <= clampu(in_tdata[277:239]);
      thv_r <= clamps(in_tdata[39:0]);
    end else if (state_r == ST_BUSY && alu_done) begin
      if (pc_r == 5'd1) thv_r <= res;
      else if (pc_r == 5'd2) gr_r <= res;
      else begin
        case (dst)
          2'd0: t0_r <= res;
          2'd1: t1_r <= res;
          2'd2: t2_r <= res;
          default: z_r <= res;
        endcase
      end
    end
    if (state_r == ST_READ) line_q_r <= line_mem[idx];
    if (state_r == ST_WRITE) line_mem[idx] <= {qr_r, qc_r, thv_r};
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = OUT_TDATA_W'(z_r);
  assign out_tuser  = interior_r;

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during output");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (32'(col_r) < MAX_COLUMNS + 1))
    else $error("column out of range");
`endif
endmodule
`default_nettype wire
